@@ hdl/sal_pkg.sv @@
// shared types and character constants for the script argument line parser
`default_nettype none
package sal_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_B   = 8'h62;

  typedef enum logic [2:0] {
    MODE_SKIP = 3'd0,
    MODE_ARG  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_OCT1 = 3'd3,
    MODE_OCT2 = 3'd4,
    MODE_DONE = 3'd5,
    MODE_ERR  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_SEP  = 2'd1,
    KIND_END  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
    logic       new_file;
  } item_t;

  typedef struct packed {
    logic       emit;
    kind_t      kind;
    logic [7:0] char_value;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/sal_if.sv @@
// valid/ready channel interfaces for input bytes and parser results
`default_nettype none
interface sal_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  logic       new_file;

  modport source (output valid, output data_byte, output end_of_file, output new_file,
                  input ready);
  modport sink (input valid, input data_byte, input end_of_file, input new_file,
                output ready);
endinterface

interface sal_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_value;

  modport source (output valid, output kind, output char_value, input ready);
  modport sink (input valid, input kind, input char_value, output ready);
endinterface
`default_nettype wire

@@ hdl/sal_in_stage.sv @@
// input register stage holding one accepted item
`default_nettype none
module sal_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sal_pkg::item_t in_item,
  input  wire logic          adv,
  output logic               s1_valid,
  output sal_pkg::item_t     s1_item
);
  import sal_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;
endmodule
`default_nettype wire

@@ hdl/sal_parse_core.sv @@
// parse mode state machine: decodes one byte per step into at most one result
`default_nettype none
module sal_parse_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire sal_pkg::item_t item,
  output sal_pkg::result_t    res
);
  import sal_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [5:0] oct_r, oct_nxt;

  mode_t      mode_eff;
  logic [5:0] oct_eff;
  logic [7:0] b;
  logic [2:0] dig;
  logic       eof;
  logic       is_oct;

  assign b      = item.data_byte;
  assign eof    = item.end_of_file;
  assign dig    = b[2:0];
  assign is_oct = (b >= CH_ZERO) && (b <= CH_SEVEN);

  always_comb begin
    // a new file restarts at line one before this byte is consumed
    mode_eff = item.new_file ? MODE_SKIP : mode_r;
    oct_eff  = item.new_file ? 6'd0 : oct_r;

    mode_nxt       = mode_eff;
    oct_nxt        = oct_eff;
    res.emit       = 1'b0;
    res.kind       = KIND_CHAR;
    res.char_value = 8'd0;

    case (mode_eff)
      MODE_SKIP: begin
        if (eof) begin
          mode_nxt = MODE_ERR;
          oct_nxt  = 6'd0;
          res.emit = 1'b1;
          res.kind = KIND_ERR;
        end else if (b == CH_NL) begin
          mode_nxt = MODE_ARG;
        end
      end
      MODE_ARG: begin
        if (eof || b == CH_NL) begin
          mode_nxt = MODE_DONE;
          res.emit = 1'b1;
          res.kind = KIND_END;
        end else if (b == CH_SPACE) begin
          res.emit = 1'b1;
          res.kind = KIND_SEP;
        end else if (b == CH_TAB) begin
          mode_nxt = MODE_ERR;
          oct_nxt  = 6'd0;
          res.emit = 1'b1;
          res.kind = KIND_ERR;
        end else if (b == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          res.emit       = 1'b1;
          res.char_value = b;
        end
      end
      MODE_ESC: begin
        if (eof) begin
          mode_nxt = MODE_ERR;
          oct_nxt  = 6'd0;
          res.emit = 1'b1;
          res.kind = KIND_ERR;
        end else if (is_oct) begin
          oct_nxt  = {3'd0, dig};
          mode_nxt = MODE_OCT1;
        end else begin
          mode_nxt = MODE_ARG;
          res.emit = 1'b1;
          if (b == CH_LC_N) begin
            res.char_value = CH_NL;
          end else if (b == CH_LC_R) begin
            res.char_value = CH_CR;
          end else if (b == CH_LC_T) begin
            res.char_value = CH_TAB;
          end else if (b == CH_LC_B) begin
            res.char_value = CH_BS;
          end else if (b == CH_BSLASH || b == CH_SPACE || b == CH_TAB || b == CH_NL) begin
            res.char_value = b;
          end else begin
            mode_nxt = MODE_ERR;
            oct_nxt  = 6'd0;
            res.kind = KIND_ERR;
          end
        end
      end
      MODE_OCT1: begin
        if (eof || !is_oct) begin
          mode_nxt = MODE_ERR;
          oct_nxt  = 6'd0;
          res.emit = 1'b1;
          res.kind = KIND_ERR;
        end else begin
          oct_nxt  = {oct_eff[2:0], dig};
          mode_nxt = MODE_OCT2;
        end
      end
      MODE_OCT2: begin
        if (eof || !is_oct) begin
          mode_nxt = MODE_ERR;
          oct_nxt  = 6'd0;
          res.emit = 1'b1;
          res.kind = KIND_ERR;
        end else begin
          // three digits make nine bits, only the low eight are kept
          oct_nxt        = 6'd0;
          mode_nxt       = MODE_ARG;
          res.emit       = 1'b1;
          res.char_value = {oct_eff[4:0], dig};
        end
      end
      default: begin
        // done, error and unused codes stay silent
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SKIP;
      oct_r  <= 6'd0;
    end else if (step) begin
      mode_r <= mode_nxt;
      oct_r  <= oct_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hdl/sal_out_stage.sv @@
// result register in front of the output channel
`default_nettype none
module sal_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire sal_pkg::result_t res,
  output logic                  slot_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_char_value
);
  import sal_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] kind_r;
  logic [7:0] char_r;

  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res.kind;
      char_r <= res.char_value;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_char_value = char_r;
endmodule
`default_nettype wire

@@ hdl/script_arg_line_parser.sv @@
// top level of the script argument line parser
//
// in_ch carries one script byte per transfer with end_of_file and new_file
// flags; new_file restarts parsing at line one before that byte is used.
// out_ch carries zero or one result per input transfer: kind 0 with the
// decoded argument character, 1 for an argument end, 2 for argument and
// list end, 3 for an error (char_value is zero for kinds 1 to 3).
// The first line is skipped; after list end or an error the block stays
// silent until a new file starts.
// Path: a result passes the input register, then the result register,
// before it is offered on out_ch. Throughput: one input item per cycle
// while out_ch does not stall, set by the mode update between the two
// registers.
// Reset (synchronous, rst_n low) empties both registers and puts the
// parser in first-line skipping. When out_ch stalls, the result register
// holds; an empty input register still takes one more item, then
// in_ch.ready drops until the result is taken. Items with no result pass
// through the parser whenever the result slot is free.
`default_nettype none
module script_arg_line_parser (
  input wire logic clk,
  input wire logic rst_n,
  sal_in_if.sink    in_ch,
  sal_out_if.source out_ch
);
  import sal_pkg::*;

  item_t   in_item;
  item_t   s1_item;
  result_t res;
  logic    s1_valid;
  logic    slot_free;
  logic    adv;

  assign in_item.data_byte   = in_ch.data_byte;
  assign in_item.end_of_file = in_ch.end_of_file;
  assign in_item.new_file    = in_ch.new_file;

  assign adv = s1_valid && slot_free;

  sal_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  sal_parse_core u_parse_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item),
    .res   (res)
  );

  sal_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (adv && res.emit),
    .res            (res),
    .slot_free      (slot_free),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_char_value (out_ch.char_value)
  );
endmodule
`default_nettype wire

@@ hdl/sal_checker.sv @@
// port-level checks for the script argument line parser, bound to the top
`default_nettype none
module sal_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_char_value
);
  import sal_pkg::*;

  // a result offered but not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_char_value))
    else $error("result changed while stalled");

  // only argument characters carry a value
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CHAR |-> out_char_value == 8'd0)
    else $error("nonzero char_value on a non-character result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind script_arg_line_parser sal_checker u_sal_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_char_value (out_ch.char_value)
);
`default_nettype wire

@@ sim/script_arg_line_parser_checker.sv @@
// result predictor and scoreboard for the script argument line parser
`default_nettype none
module script_arg_line_parser_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  sal_in_if         in_ch,
  sal_out_if        out_ch,
  output int        fail_count,
  output int        pending,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sal_pkg::*;

  mode_t      parse_state;
  logic [5:0] octal_acc;
  result_t    arg_results_q[$];
  int         mismatches;
  int         results_seen;

  // advances the parser state by one byte, returns 1 when a result comes out
  function automatic bit decode_arg_byte(input logic [7:0] b, input logic eof,
                                         input logic nf, output result_t r);
    bit emits;
    bit err;
    bit is_oct;
    emits = 1'b0;
    err = 1'b0;
    is_oct = (b >= CH_ZERO) && (b <= CH_SEVEN);
    r.emit = 1'b1;
    r.kind = KIND_CHAR;
    r.char_value = '0;
    if (nf) begin
      parse_state = MODE_SKIP;
      octal_acc = '0;
    end
    case (parse_state)
      MODE_SKIP: begin
        if (eof) err = 1'b1;
        else if (b == CH_NL) parse_state = MODE_ARG;
      end
      MODE_ARG: begin
        if (eof || b == CH_NL) begin
          parse_state = MODE_DONE;
          emits = 1'b1;
          r.kind = KIND_END;
        end else if (b == CH_SPACE) begin
          emits = 1'b1;
          r.kind = KIND_SEP;
        end else if (b == CH_TAB) begin
          err = 1'b1;
        end else if (b == CH_BSLASH) begin
          parse_state = MODE_ESC;
        end else begin
          emits = 1'b1;
          r.char_value = b;
        end
      end
      MODE_ESC: begin
        if (eof) begin
          err = 1'b1;
        end else if (is_oct) begin
          octal_acc = {3'b000, b[2:0]};
          parse_state = MODE_OCT1;
        end else begin
          parse_state = MODE_ARG;
          emits = 1'b1;
          case (b)
            CH_LC_N: r.char_value = CH_NL;
            CH_LC_R: r.char_value = CH_CR;
            CH_LC_T: r.char_value = CH_TAB;
            CH_LC_B: r.char_value = CH_BS;
            CH_BSLASH, CH_SPACE, CH_TAB, CH_NL: r.char_value = b;
            default: err = 1'b1;
          endcase
        end
      end
      MODE_OCT1: begin
        if (eof || !is_oct) begin
          err = 1'b1;
        end else begin
          octal_acc = {octal_acc[2:0], b[2:0]};
          parse_state = MODE_OCT2;
        end
      end
      MODE_OCT2: begin
        if (eof || !is_oct) begin
          err = 1'b1;
        end else begin
          // third digit: anything above 255 keeps its low 8 bits
          r.char_value = {octal_acc[4:0], b[2:0]};
          octal_acc = '0;
          parse_state = MODE_ARG;
          emits = 1'b1;
        end
      end
      default: ;
    endcase
    if (err) begin
      parse_state = MODE_ERR;
      octal_acc = '0;
      emits = 1'b1;
      r.kind = KIND_ERR;
      r.char_value = '0;
    end
    return emits;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t nxt;
    bit      emits;
    if (!rst_n) begin
      parse_state = MODE_SKIP;
      octal_acc = '0;
      arg_results_q.delete();
    end else begin
      // result side first: a result never belongs to the same-edge input transfer
      if (out_ch.valid && out_ch.ready) begin
        if (arg_results_q.size() == 0) begin
          $error("unexpected result: kind %0d char_value 0x%02h",
                 out_ch.kind, out_ch.char_value);
          mismatches++;
        end else begin
          want = arg_results_q.pop_front();
          results_seen++;
          if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
            mismatches++;
          end
          if (out_ch.char_value !== want.char_value) begin
            $error("char_value: expected 0x%02h, got 0x%02h",
                   want.char_value, out_ch.char_value);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        emits = decode_arg_byte(in_ch.data_byte, in_ch.end_of_file, in_ch.new_file, nxt);
        if (emits) arg_results_q.push_back(nxt);
      end
    end
    fail_count <= mismatches;
    pending <= arg_results_q.size();
    checked <= results_seen;
  end

endmodule
`default_nettype wire

@@ sim/script_arg_line_parser_tb.sv @@
// stimulus, flow control and verdict for the script argument line parser
`default_nettype none
module script_arg_line_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sal_pkg::*;

  localparam int N_ITEMS        = 900;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;

  logic clk;
  logic rst_n;

  sal_in_if  in_ch();
  sal_out_if out_ch();

  int fail_count;
  int pending;
  int checked;

  int n_items;
  int n_scripts;
  int burst_left;
  int quiet_cycles = 0;
  int hold_trigger;
  int hold_seen;
  int hold_left;
  int rx_left;
  int rx_pattern;
  int rx_phase;

  logic [7:0] esc_codes [8] = '{CH_LC_N, CH_LC_R, CH_LC_T, CH_LC_B,
                                CH_BSLASH, CH_SPACE, CH_TAB, CH_NL};

  script_arg_line_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  script_arg_line_parser_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // offers one byte in bursts with random gaps and returns at its transfer
  task automatic send_item(input logic [7:0] b, input bit eof, input bit nf,
                           input bit tally);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_file <= eof;
    in_ch.new_file    <= nf;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (tally) n_items++;
  endtask

  // one well-formed script with random content, sometimes broken on line two
  task automatic send_script();
    int         len;
    int         ntok;
    int         k;
    int         pick;
    int         ndig;
    bit         broken;
    logic [7:0] b;
    n_scripts++;
    len = $urandom_range(0, 5);
    for (k = 0; k < len; k++) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
      send_item(b, 1'b0, k == 0, 1'b1);
    end
    send_item(CH_NL, 1'b0, len == 0, 1'b1);
    ntok = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 14);
    broken = 1'b0;
    k = 0;
    while (k < ntok && !broken) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_NL || b == CH_SPACE || b == CH_TAB || b == CH_BSLASH);
        send_item(b, 1'b0, 1'b0, 1'b1);
      end else if (pick < 70) begin
        send_item(CH_SPACE, 1'b0, 1'b0, 1'b1);
      end else if (pick < 80) begin
        send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
        send_item(esc_codes[$urandom_range(0, 7)], 1'b0, 1'b0, 1'b1);
      end else if (pick < 92) begin
        send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
        repeat (3) send_item(8'(CH_ZERO + $urandom_range(0, 7)), 1'b0, 1'b0, 1'b1);
      end else begin
        broken = 1'b1;
        case ($urandom_range(0, 2))
          0: send_item(CH_TAB, 1'b0, 1'b0, 1'b1);
          1: begin
            send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
            do b = 8'($urandom_range(0, 255));
            while ((b >= CH_ZERO && b <= CH_SEVEN) || b == CH_LC_N || b == CH_LC_R ||
                   b == CH_LC_T || b == CH_LC_B || b == CH_BSLASH || b == CH_SPACE ||
                   b == CH_TAB || b == CH_NL);
            send_item(b, 1'b0, 1'b0, 1'b1);
          end
          default: begin
            // escape cut short: zero to two digits, then end of file or a non-digit
            send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
            ndig = $urandom_range(0, 2);
            repeat (ndig) send_item(8'(CH_ZERO + $urandom_range(0, 7)), 1'b0, 1'b0, 1'b1);
            if (ndig == 0 || $urandom_range(0, 1)) begin
              send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b1);
            end else begin
              do b = 8'($urandom_range(0, 255)); while (b >= CH_ZERO && b <= CH_SEVEN);
              send_item(b, 1'b0, 1'b0, 1'b1);
            end
          end
        endcase
      end
      k++;
    end
    if (!broken) begin
      if ($urandom_range(0, 1)) send_item(CH_NL, 1'b0, 1'b0, 1'b1);
      else send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b1);
    end
    // trailing bytes land in a silent state
    repeat ($urandom_range(0, 2))
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
  endtask

  // receiver: changing stall patterns plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
      rx_left = 0;
    end else if (hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      hold_left = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_pattern = $urandom_range(0, 3);
        rx_left = $urandom_range(5, 60);
        rx_phase = 0;
      end
      rx_left--;
      rx_phase++;
      case (rx_pattern)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (rx_phase % 3) != 0;
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("script_arg_line_parser: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    logic [7:0] b;
    bit         held;
    bit         paused;
    held = 1'b0;
    paused = 1'b0;
    n_items = 0;
    n_scripts = 0;
    burst_left = 0;
    hold_trigger = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.end_of_file <= 1'b0;
    in_ch.new_file    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty first line, then byte extremes, a space and escapes
    send_item(CH_NL, 1'b0, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0, 1'b1);
    send_item(CH_SPACE, 1'b0, 1'b0, 1'b1);
    // octal 777 truncates to 0xff
    send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
    repeat (3) send_item(CH_SEVEN, 1'b0, 1'b0, 1'b1);
    send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
    send_item(CH_LC_N, 1'b0, 1'b0, 1'b1);
    send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
    send_item(CH_TAB, 1'b0, 1'b0, 1'b1);
    // end of file right after a backslash, then a byte in the error state
    send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
    send_item(8'hA5, 1'b1, 1'b0, 1'b1);
    send_item(8'h78, 1'b0, 1'b0, 1'b1);
    // bare tab
    send_item(CH_NL, 1'b0, 1'b1, 1'b1);
    send_item(CH_TAB, 1'b0, 1'b0, 1'b1);
    // unknown escape code
    send_item(CH_NL, 1'b0, 1'b1, 1'b1);
    send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
    send_item(8'h71, 1'b0, 1'b0, 1'b1);
    // octal cut short by a non-digit
    send_item(CH_NL, 1'b0, 1'b1, 1'b1);
    send_item(CH_BSLASH, 1'b0, 1'b0, 1'b1);
    send_item(8'(CH_ZERO + 1), 1'b0, 1'b0, 1'b1);
    send_item(8'(CH_ZERO + 8), 1'b0, 1'b0, 1'b1);
    // end of file on line one
    send_item(8'h5A, 1'b1, 1'b1, 1'b1);
    // end of file on an empty second line, then a byte in the done state
    send_item(CH_NL, 1'b0, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0, 1'b1);
    send_item(8'h7A, 1'b0, 1'b0, 1'b1);

    while (n_items < N_ITEMS) begin
      if (!held && n_items >= N_ITEMS / 3) begin
        held = 1'b1;
        hold_trigger <= hold_trigger + 1;
      end
      if (!paused && n_items >= 2 * N_ITEMS / 3) begin
        // sender waits until every expected result has come out
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) < 8) begin
        send_script();
      end else begin
        repeat ($urandom_range(1, 10)) begin
          b = $urandom_range(0, 1) ? esc_codes[$urandom_range(0, 7)]
                                   : 8'($urandom_range(0, 255));
          send_item(b, $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0, 1'b1);
        end
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d input transfers over %0d scripts plus noise bursts,",
             n_items, n_scripts);
    $display("with one long result hold and one drain pause; %0d results compared",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("script_arg_line_parser: match");
    end else begin
      $display("script_arg_line_parser: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
